### rtl/dosq_pkg.sv
// Shared types and constants for the drop-oldest slot queue.
package dosq_pkg;

	localparam int SIZE_W  = 25;
	localparam int TIME_W  = 48;
	localparam int ALIGN_SHIFT = 6;   // slot capacity rounds up to 64 bytes
	localparam int CNT32_W = 32;
	localparam int SLOT_OUT_W = 4;
	localparam int QUEUED_OUT_W = 5;

	// Slot occupancy marks
	typedef enum logic [1:0] {
		MARK_FREE   = 2'd0,
		MARK_QUEUED = 2'd1,
		MARK_HELD   = 2'd2
	} mark_t;

	// Operation codes carried on the input tuser
	typedef enum logic [1:0] {
		OP_ENQ = 2'd0,
		OP_ACQ = 2'd1,
		OP_REL = 2'd2
	} op_t;

	// Result status codes
	typedef enum logic [2:0] {
		STAT_OK        = 3'd0,
		STAT_STOPPED   = 3'd1,
		STAT_TOO_LARGE = 3'd2,
		STAT_NO_ROOM   = 3'd3,
		STAT_EMPTY     = 3'd4,
		STAT_HELD      = 3'd5,
		STAT_NONE_HELD = 3'd6
	} status_t;

	// Register word index on the configuration port
	typedef enum logic {
		REG_SLOT_BYTES    = 1'b0,
		REG_QUEUE_RUNNING = 1'b1
	} reg_idx_t;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE   = 2'd0,
		ST_DECIDE = 2'd1,
		ST_SCAN   = 2'd2,
		ST_FINISH = 2'd3
	} state_t;

	// Work left for the scan and finish steps
	typedef enum logic [1:0] {
		JOB_REPORT = 2'd0,
		JOB_ENQ    = 2'd1,
		JOB_DROP   = 2'd2,
		JOB_ACQ    = 2'd3
	} job_t;

	// Scanner request and result
	typedef struct packed {
		logic  go;
		mark_t want;
	} scan_ctl_t;

	typedef struct packed {
		logic done;
		logic found;
	} scan_stat_t;

endpackage

### rtl/dosq_scan.sv
// Mark scanner: walks the slot ring one mark per cycle looking for a wanted mark.
module dosq_scan
	import dosq_pkg::*;
#(
	parameter int SLOTS = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  scan_ctl_t                  ctl,
	input  logic [$clog2(SLOTS)-1:0]   from,
	input  mark_t                      mark_rd,
	output logic [$clog2(SLOTS)-1:0]   pos,
	output scan_stat_t                 stat
);

	localparam int IDX_W = $clog2(SLOTS);

	logic             busy_q;
	logic [IDX_W-1:0] pos_q;
	logic [IDX_W-1:0] cnt_q;
	mark_t            want_q;

	// Compare the current mark; stop on a match or after the whole ring
	assign pos        = pos_q;
	assign stat.found = (mark_rd == want_q);
	assign stat.done  = busy_q && ((mark_rd == want_q) || (cnt_q == IDX_W'(SLOTS - 1)));

	// Advance the position one slot a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= '0;
			cnt_q  <= '0;
			want_q <= MARK_FREE;
		end else if (ctl.go) begin
			busy_q <= 1'b1;
			pos_q  <= from;
			cnt_q  <= '0;
			want_q <= ctl.want;
		end else if (stat.done) begin
			busy_q <= 1'b0;
		end else if (busy_q) begin
			pos_q <= pos_q + IDX_W'(1);
			cnt_q <= cnt_q + IDX_W'(1);
		end
	end

endmodule

### rtl/drop_oldest_slot_queue.sv
// Top level of the drop-oldest slot queue: sequencer, slot marks and slot store.
//
// Input stream (s_*): s_tuser carries the operation (enqueue, acquire oldest,
// release held slot); s_tdata carries packet size and timestamp. Output stream
// (m_*): one result per input transfer, m_tuser the status, m_tdata the slot
// index, stored size and time of an acquired slot, drop flag and counters.
// The APB port sets slot capacity (rounded up to 64 bytes) and the run flag.
//
// One item is handled at a time. An item passes from DECIDE straight to the
// FINISH step when no search is needed (errors, release, acquire or drop
// with a single queued entry), and through SCAN when the ring is searched:
// the search reads one slot mark per cycle through a shared scanner.
// s_tready is high only while the sequencer is idle, so a new transfer is
// taken only after the finish step of the previous item.
//
// A finished result sits in an output register; the next item is accepted
// while it waits, and only its finish step stalls until m_tready frees the
// register. Reset frees all slots, clears pointers and counters, sets slot
// capacity to 65536 bytes and the queue running.
module drop_oldest_slot_queue
	import dosq_pkg::*;
#(
	parameter int SLOTS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	// input stream
	input  logic          s_tvalid,
	output logic          s_tready,
	input  logic [79:0]   s_tdata,   // packet_size[24:0], packet_time[72:25]
	input  logic [1:0]    s_tuser,   // op[1:0]
	// output stream
	output logic          m_tvalid,
	input  logic          m_tready,
	// slot_index[3:0], out_size[28:4], out_time[76:29], dropped[77],
	// drops_total[109:78], released_total[141:110], queued_now[146:142]
	output logic [151:0]  m_tdata,
	output logic [2:0]    m_tuser,   // status[2:0]
	// configuration
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);

	localparam int IDX_W = $clog2(SLOTS);
	localparam int CNT_W = $clog2(SLOTS + 1);

	// Configuration registers
	logic [SIZE_W-1:0] slot_bytes_q;
	logic              running_q;

	// Sequencer and item registers
	state_t              state_q, state_d;
	op_t                 op_q;
	logic [SIZE_W-1:0]   size_q;
	logic [TIME_W-1:0]   time_q;
	job_t                job_q, job_d;
	status_t             status_q, status_d;
	logic [IDX_W-1:0]    tgt_q, tgt_d;
	logic                dropped_q, dropped_d;

	// Queue state
	logic [IDX_W-1:0]    rp_q, rp_d;
	logic [IDX_W-1:0]    wp_q, wp_d;
	logic [CNT_W-1:0]    queued_q, queued_d;
	logic                holding_q, holding_d;
	logic [IDX_W-1:0]    held_q, held_d;
	logic [CNT32_W-1:0]  drops_q, drops_d;
	logic [CNT32_W-1:0]  rel_q, rel_d;

	// Slot marks and store
	mark_t                      mark_q [SLOTS];
	logic                       mark_we;
	logic [IDX_W-1:0]           mark_addr;
	mark_t                      mark_wdata;
	logic [TIME_W+SIZE_W-1:0]   mem [SLOTS];
	logic [TIME_W+SIZE_W-1:0]   rd_data_q;
	logic                       mem_we;
	logic                       rd_en;

	// Scanner
	scan_ctl_t           scan_ctl;
	scan_stat_t          scan_stat;
	logic [IDX_W-1:0]    scan_from;
	logic [IDX_W-1:0]    scan_pos;
	mark_t               scan_mark;

	// Output register
	logic                m_tvalid_q;
	logic [151:0]        m_tdata_q;
	logic [2:0]          m_tuser_q;
	logic                out_load;

	// Datapath helpers
	logic [SIZE_W-ALIGN_SHIFT:0] cap_units;
	logic [SIZE_W:0]             cap_bytes;
	logic                        too_large;
	logic [CNT_W:0]              occupied;
	logic                        ring_full;
	logic [IDX_W+SLOT_OUT_W-1:0]   slot_wide;
	logic [CNT_W+QUEUED_OUT_W-1:0] queued_wide;
	logic                        cfg_wr;

	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_bytes_q <= SIZE_W'(65536);
			running_q    <= 1'b1;
		end else if (cfg_wr) begin
			unique case (reg_idx_t'(paddr[2]))
				REG_SLOT_BYTES:    slot_bytes_q <= pwdata[SIZE_W-1:0];
				REG_QUEUE_RUNNING: running_q    <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[2]))
			REG_SLOT_BYTES:    prdata = {{(32-SIZE_W){1'b0}}, slot_bytes_q};
			REG_QUEUE_RUNNING: prdata = {31'b0, running_q};
			default:           prdata = '0;
		endcase
	end

	// Capacity check and ring occupancy
	assign cap_units = {1'b0, slot_bytes_q[SIZE_W-1:ALIGN_SHIFT]}
	                 + (SIZE_W-ALIGN_SHIFT+1)'(|slot_bytes_q[ALIGN_SHIFT-1:0]);
	assign cap_bytes = {cap_units, {ALIGN_SHIFT{1'b0}}};
	assign too_large = ({1'b0, size_q} > cap_bytes);
	assign occupied  = {1'b0, queued_q} + (CNT_W+1)'(holding_q);
	assign ring_full = (occupied >= (CNT_W+1)'(SLOTS));

	// Shared mark scanner
	assign scan_mark = mark_q[scan_pos];

	dosq_scan #(
		.SLOTS (SLOTS)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (scan_ctl),
		.from    (scan_from),
		.mark_rd (scan_mark),
		.pos     (scan_pos),
		.stat    (scan_stat)
	);

	assign s_tready = (state_q == ST_IDLE);

	// Next state, queue updates and strobes
	always_comb begin
		state_d    = state_q;
		job_d      = job_q;
		status_d   = status_q;
		tgt_d      = tgt_q;
		dropped_d  = dropped_q;
		rp_d       = rp_q;
		wp_d       = wp_q;
		queued_d   = queued_q;
		holding_d  = holding_q;
		held_d     = held_q;
		drops_d    = drops_q;
		rel_d      = rel_q;
		scan_ctl   = '{go: 1'b0, want: MARK_QUEUED};
		scan_from  = rp_q + IDX_W'(1);
		mark_we    = 1'b0;
		mark_addr  = rp_q;
		mark_wdata = MARK_FREE;
		mem_we     = 1'b0;
		rd_en      = 1'b0;
		out_load   = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_DECIDE;
				end
			end

			ST_DECIDE: begin
				state_d   = ST_FINISH;
				status_d  = STAT_OK;
				job_d     = JOB_REPORT;
				tgt_d     = '0;
				dropped_d = 1'b0;
				rd_en     = 1'b1;
				unique case (op_q)
					OP_ENQ: begin
						if (too_large) begin
							status_d = STAT_TOO_LARGE;
						end else if (!running_q) begin
							status_d = STAT_STOPPED;
						end else if (ring_full) begin
							if (queued_q == '0) begin
								status_d = STAT_NO_ROOM;
							end else begin
								// drop the oldest entry and reuse its slot
								job_d      = JOB_DROP;
								tgt_d      = rp_q;
								mark_we    = 1'b1;
								mark_addr  = rp_q;
								mark_wdata = MARK_FREE;
								drops_d    = drops_q + CNT32_W'(1);
								dropped_d  = 1'b1;
								if (queued_q != CNT_W'(1)) begin
									scan_ctl = '{go: 1'b1, want: MARK_QUEUED};
									state_d  = ST_SCAN;
								end
							end
						end else begin
							job_d     = JOB_ENQ;
							scan_from = wp_q;
							scan_ctl  = '{go: 1'b1, want: MARK_FREE};
							state_d   = ST_SCAN;
						end
					end
					OP_ACQ: begin
						if (queued_q == '0) begin
							status_d = STAT_EMPTY;
						end else if (holding_q) begin
							status_d = STAT_HELD;
						end else begin
							// hand out the oldest entry
							job_d      = JOB_ACQ;
							tgt_d      = rp_q;
							mark_we    = 1'b1;
							mark_addr  = rp_q;
							mark_wdata = MARK_HELD;
							held_d     = rp_q;
							holding_d  = 1'b1;
							queued_d   = queued_q - CNT_W'(1);
							if (queued_q == CNT_W'(1)) begin
								rp_d = rp_q + IDX_W'(1);
							end else begin
								scan_ctl = '{go: 1'b1, want: MARK_QUEUED};
								state_d  = ST_SCAN;
							end
						end
					end
					OP_REL: begin
						if (!holding_q) begin
							status_d = STAT_NONE_HELD;
						end else begin
							tgt_d      = held_q;
							mark_we    = 1'b1;
							mark_addr  = held_q;
							mark_wdata = MARK_FREE;
							holding_d  = 1'b0;
							rel_d      = rel_q + CNT32_W'(1);
						end
					end
					default: ;
				endcase
			end

			ST_SCAN: begin
				if (scan_stat.done) begin
					state_d = ST_FINISH;
					case (job_q)
						JOB_ENQ: begin
							if (scan_stat.found) begin
								tgt_d = scan_pos;
							end else begin
								status_d = STAT_NO_ROOM;
								job_d    = JOB_REPORT;
							end
						end
						JOB_DROP, JOB_ACQ: begin
							rp_d = scan_stat.found ? scan_pos : tgt_q + IDX_W'(1);
						end
						default: ;
					endcase
				end
			end

			ST_FINISH: begin
				if (!m_tvalid_q || m_tready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
					if (job_q == JOB_ENQ || job_q == JOB_DROP) begin
						// commit the enqueue into the target slot
						mem_we     = 1'b1;
						mark_we    = 1'b1;
						mark_addr  = tgt_q;
						mark_wdata = MARK_QUEUED;
						wp_d       = tgt_q + IDX_W'(1);
						if (job_q == JOB_ENQ) begin
							queued_d = queued_q + CNT_W'(1);
						end
						if ((job_q == JOB_ENQ && queued_q == '0) ||
						    (job_q == JOB_DROP && queued_q == CNT_W'(1))) begin
							rp_d = tgt_q;
						end
					end
				end
			end

			default: ;
		endcase
	end

	// Sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Queue control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_q     <= JOB_REPORT;
			status_q  <= STAT_OK;
			tgt_q     <= '0;
			dropped_q <= 1'b0;
			rp_q      <= '0;
			wp_q      <= '0;
			queued_q  <= '0;
			holding_q <= 1'b0;
			held_q    <= '0;
			drops_q   <= '0;
			rel_q     <= '0;
		end else begin
			job_q     <= job_d;
			status_q  <= status_d;
			tgt_q     <= tgt_d;
			dropped_q <= dropped_d;
			rp_q      <= rp_d;
			wp_q      <= wp_d;
			queued_q  <= queued_d;
			holding_q <= holding_d;
			held_q    <= held_d;
			drops_q   <= drops_d;
			rel_q     <= rel_d;
		end
	end

	// Capture the input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= OP_ENQ;
		end else if (s_tvalid && s_tready) begin
			op_q <= op_t'(s_tuser);
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			size_q <= s_tdata[SIZE_W-1:0];
			time_q <= s_tdata[SIZE_W+TIME_W-1:SIZE_W];
		end
	end

	// Slot marks, all free after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				mark_q[i] <= MARK_FREE;
			end
		end else if (mark_we) begin
			mark_q[mark_addr] <= mark_wdata;
		end
	end

	// Slot store: size and timestamp, read registered at the oldest entry
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[tgt_q] <= {time_q, size_q};
		end
		if (rd_en) begin
			rd_data_q <= mem[rp_q];
		end
	end

	// Result fields
	assign slot_wide   = {{SLOT_OUT_W{1'b0}}, tgt_q};
	assign queued_wide = {{QUEUED_OUT_W{1'b0}}, queued_d};

	// Output register; hold until the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tuser_q <= status_q;
			m_tdata_q <= {
				5'b0,
				queued_wide[QUEUED_OUT_W-1:0],
				rel_q,
				drops_q,
				dropped_q,
				(job_q == JOB_ACQ) ? rd_data_q : {(TIME_W+SIZE_W){1'b0}},
				slot_wide[SLOT_OUT_W-1:0]
			};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

### dv/drop_oldest_slot_queue_test.sv
`timescale 1ns / 100ps
// Self-checking testbench for the drop-oldest slot queue: stream stimulus, APB setup, scoreboard.
module drop_oldest_slot_queue_test;
	import dosq_pkg::*;

	localparam int SLOTS = 16;
	localparam logic [1:0] OP_IDLE = 2'd3;     // unused op code, must act as a no-op
	localparam int QUIET_LIMIT = 4000;
	localparam int SETTLE_CYCLES = SLOTS + 8;
	localparam int PHASES = 8;
	localparam int unsigned PHASE_BYTES [PHASES] =
		'{65536, 0, 1, 16777216, 100, 4096, 16777215, 200};
	localparam bit PHASE_RUN [PHASES] = '{1, 1, 1, 0, 1, 0, 1, 1};
	localparam int PHASE_ITEMS [PHASES] = '{300, 120, 200, 60, 200, 60, 200, 100};

	typedef struct packed {
		status_t             status;
		logic [3:0]          slot;
		logic [SIZE_W-1:0]   size;
		logic [TIME_W-1:0]   stamp;
		logic                dropped;
		logic [31:0]         drops;
		logic [31:0]         releases;
		logic [4:0]          queued;
	} slot_result_t;

	// Tracks the slot ring and holds the results still owed by the block
	class slot_queue_ledger;
		mark_t             mark [SLOTS];
		logic [SIZE_W-1:0] length [SLOTS];
		logic [TIME_W-1:0] stamp [SLOTS];
		logic [3:0]        rd_ptr;
		logic [3:0]        wr_ptr;
		logic [3:0]        held_slot;
		logic              holding;
		int                queued;
		logic [31:0]       drop_count;
		logic [31:0]       release_count;
		logic [SIZE_W-1:0] slot_bytes;
		logic              running;
		slot_result_t      awaited [$];
		int                items;
		int                results;
		int                failures;
		int                reported;
		int                status_seen [8];

		function new();
			for (int k = 0; k < SLOTS; k++)
				free_slot(4'(k));
			rd_ptr = '0;
			wr_ptr = '0;
			held_slot = '0;
			holding = 1'b0;
			queued = 0;
			drop_count = '0;
			release_count = '0;
			slot_bytes = 25'd65536;
			running = 1'b1;
			items = 0;
			results = 0;
			failures = 0;
			reported = 0;
			foreach (status_seen[i])
				status_seen[i] = 0;
		endfunction

		function void free_slot(logic [3:0] k);
			mark[k] = MARK_FREE;
			length[k] = '0;
			stamp[k] = '0;
		endfunction

		function int unsigned capacity();
			return ({7'd0, slot_bytes} + 32'd63) & ~32'd63;
		endfunction

		// Search the ring from start, wrapping, for the first slot with the wanted mark
		function bit find_mark(logic [3:0] start, mark_t want, output logic [3:0] at);
			at = '0;
			for (int i = 0; i < SLOTS; i++) begin
				if (mark[start + 4'(i)] == want) begin
					at = start + 4'(i);
					return 1'b1;
				end
			end
			return 1'b0;
		endfunction

		function void set_register(reg_idx_t idx, logic [31:0] value);
			case (idx)
				REG_SLOT_BYTES: slot_bytes = value[SIZE_W-1:0];
				REG_QUEUE_RUNNING: running = value[0];
				default: ;
			endcase
		endfunction

		// Advance the ring for one accepted transfer and queue the result it owes
		function void apply_op(logic [1:0] op, logic [SIZE_W-1:0] size,
				logic [TIME_W-1:0] ts);
			slot_result_t r;
			logic [3:0] at;
			logic [3:0] nxt;
			logic [3:0] found;
			bit placed;
			r = '0;
			at = '0;
			items++;
			case (op)
				OP_ENQ: begin
					if ({7'd0, size} > capacity())
						r.status = STAT_TOO_LARGE;
					else if (!running)
						r.status = STAT_STOPPED;
					else begin
						placed = 1'b1;
						if (queued + holding >= SLOTS) begin
							// ring full: drop the oldest queued entry and reuse its slot
							if (queued == 0)
								placed = 1'b0;
							else begin
								at = rd_ptr;
								nxt = at + 4'd1;
								free_slot(at);
								rd_ptr = find_mark(nxt, MARK_QUEUED, found) ? found : nxt;
								queued--;
								drop_count++;
								r.dropped = 1'b1;
							end
						end else
							placed = find_mark(wr_ptr, MARK_FREE, at);
						if (!placed)
							r.status = STAT_NO_ROOM;
						else begin
							length[at] = size;
							stamp[at] = ts;
							mark[at] = MARK_QUEUED;
							if (queued == 0)
								rd_ptr = at;
							queued++;
							wr_ptr = at + 4'd1;
							r.slot = at;
						end
					end
				end
				OP_ACQ: begin
					if (queued == 0)
						r.status = STAT_EMPTY;
					else if (holding)
						r.status = STAT_HELD;
					else begin
						at = rd_ptr;
						nxt = at + 4'd1;
						mark[at] = MARK_HELD;
						held_slot = at;
						holding = 1'b1;
						queued--;
						if (queued != 0 && find_mark(nxt, MARK_QUEUED, found))
							rd_ptr = found;
						else
							rd_ptr = nxt;
						r.slot = at;
						r.size = length[at];
						r.stamp = stamp[at];
					end
				end
				OP_REL: begin
					if (!holding)
						r.status = STAT_NONE_HELD;
					else begin
						free_slot(held_slot);
						holding = 1'b0;
						release_count++;
						r.slot = held_slot;
					end
				end
				default: ;
			endcase
			r.drops = drop_count;
			r.releases = release_count;
			r.queued = 5'(queued);
			status_seen[r.status]++;
			awaited.push_back(r);
		endfunction

		function void compare(string field, logic [63:0] want, logic [63:0] got);
			if (got !== want) begin
				failures++;
				if (reported < 10)
					$display("result %0d: %s expected 0x%0h, got 0x%0h",
						results, field, want, got);
				reported++;
			end
		endfunction

		// Match one output transfer against the oldest owed result
		function void check_result(slot_result_t got);
			slot_result_t want;
			results++;
			if (awaited.size() == 0) begin
				failures++;
				if (reported < 10)
					$display("result %0d: arrived with nothing owed (status %0d)",
						results, got.status);
				reported++;
				return;
			end
			want = awaited.pop_front();
			compare("status", want.status, got.status);
			compare("slot_index", want.slot, got.slot);
			compare("out_size", want.size, got.size);
			compare("out_time", want.stamp, got.stamp);
			compare("dropped", want.dropped, got.dropped);
			compare("drops_total", want.drops, got.drops);
			compare("released_total", want.releases, got.releases);
			compare("queued_now", want.queued, got.queued);
		endfunction
	endclass

	logic          clk;
	logic          arst_n = 1'b0;
	logic          s_tvalid = 1'b0;
	logic          s_tready;
	logic [79:0]   s_tdata = '0;    // packet_size[24:0], packet_time[72:25]
	logic [1:0]    s_tuser = '0;    // op[1:0]
	logic          m_tvalid;
	logic          m_tready = 1'b0;
	// slot_index[3:0], out_size[28:4], out_time[76:29], dropped[77],
	// drops_total[109:78], released_total[141:110], queued_now[146:142]
	logic [151:0]  m_tdata;
	logic [2:0]    m_tuser;         // status[2:0]
	logic          psel = 1'b0;
	logic          penable = 1'b0;
	logic          pwrite = 1'b0;
	logic [2:0]    paddr = '0;
	logic [31:0]   pwdata = '0;
	logic [31:0]   prdata;
	logic          pready;

	slot_queue_ledger ledger = new();
	slot_result_t     seen_result;
	int               tx_max = 12;
	int               rx_max = 12;
	logic [3:0]       rx_wait = '0;

	drop_oldest_slot_queue #(.SLOTS(SLOTS)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Check output transfers first, then note input transfers
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			seen_result.status = status_t'(m_tuser);
			seen_result.slot = m_tdata[3:0];
			seen_result.size = m_tdata[28:4];
			seen_result.stamp = m_tdata[76:29];
			seen_result.dropped = m_tdata[77];
			seen_result.drops = m_tdata[109:78];
			seen_result.releases = m_tdata[141:110];
			seen_result.queued = m_tdata[146:142];
			ledger.check_result(seen_result);
		end
		if (arst_n && s_tvalid && s_tready)
			ledger.apply_op(s_tuser, s_tdata[24:0], s_tdata[72:25]);
	end

	// Receiver: after each transfer hold tready low for a random stall
	always @(posedge clk) begin : receiver
		int stall;
		if (m_tvalid && m_tready) begin
			stall = $urandom_range(0, rx_max);
			if (stall != 0) begin
				m_tready <= 1'b0;
				rx_wait <= 4'(stall - 1);
			end
		end else if (!m_tready) begin
			if (rx_wait == 0)
				m_tready <= 1'b1;
			else
				rx_wait <= rx_wait - 4'd1;
		end
	end

	// End the run when nothing moves for too long
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
				quiet = 0;
			else
				quiet++;
		end
		$display("CHECK FAILED");
		$finish;
	end

	task automatic send_item(input logic [1:0] op, input logic [SIZE_W-1:0] size,
			input logic [TIME_W-1:0] ts);
		int gap;
		gap = $urandom_range(0, tx_max);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {7'd0, ts, size};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// Stop sending and wait for every owed result plus a settling margin
	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (ledger.awaited.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		ledger.set_register(idx, value);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input int unsigned bytes, input bit run);
		drain_results();
		write_reg(REG_SLOT_BYTES, bytes);
		write_reg(REG_QUEUE_RUNNING, {31'd0, run});
	endtask

	// Sizes cluster on the capacity edge, with some far out of range
	function automatic logic [SIZE_W-1:0] pick_size();
		int unsigned cap;
		cap = ledger.capacity();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return SIZE_W'(cap);
			2: return SIZE_W'(cap + 1);
			3: return SIZE_W'($urandom);
			default: return SIZE_W'($urandom_range(0, cap));
		endcase
	endfunction

	// Random traffic in segments that fill, drain or balance the ring
	task automatic run_random(input int count);
		int profile;
		int roll;
		logic [1:0] op;
		profile = 2;
		for (int n = 0; n < count; n++) begin
			if (n % 40 == 0) begin
				profile = $urandom_range(0, 2);
				tx_max = ($urandom_range(0, 3) == 0) ? 0 : 12;
				rx_max <= ($urandom_range(0, 3) == 0) ? 0 : 12;
			end
			if ($urandom_range(0, 99) == 0)
				drain_results();
			roll = $urandom_range(0, 99);
			case (profile)
				0: op = roll < 70 ? OP_ENQ : roll < 84 ? OP_ACQ : roll < 98 ? OP_REL : OP_IDLE;
				1: op = roll < 15 ? OP_ENQ : roll < 56 ? OP_ACQ : roll < 98 ? OP_REL : OP_IDLE;
				default: op = roll < 40 ? OP_ENQ : roll < 68 ? OP_ACQ : roll < 96 ? OP_REL : OP_IDLE;
			endcase
			send_item(op, pick_size(), {16'($urandom), $urandom});
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty ring, idle op, capacity edges at the reset setting
		send_item(OP_REL, '0, '0);
		send_item(OP_ACQ, '0, '0);
		send_item(OP_IDLE, '1, '1);
		send_item(OP_ENQ, '0, '0);
		send_item(OP_ENQ, 25'd65536, 48'hFFFF_FFFF_FFFF);
		send_item(OP_ENQ, 25'd65537, 48'h1234_5678_9ABC);
		send_item(OP_ENQ, 25'h1FF_FFFF, 48'hFFFF_FFFF_FFFF);
		send_item(OP_ACQ, '0, '0);
		send_item(OP_ACQ, '0, '0);
		send_item(OP_REL, '0, '0);
		send_item(OP_REL, '0, '0);
		send_item(OP_ACQ, '0, '0);
		// empty takes precedence over already held
		send_item(OP_ACQ, '0, '0);
		send_item(OP_REL, '0, '0);

		// Zero capacity admits only empty packets
		configure(0, 1'b1);
		send_item(OP_ENQ, '0, 48'hA5A5_5A5A_A5A5);
		send_item(OP_ENQ, 25'd1, 48'h5A5A_A5A5_5A5A);

		// Stopped: size check first, acquire and release still served
		configure(16777216, 1'b0);
		send_item(OP_ENQ, 25'h1FF_FFFF, 48'h0000_0000_0001);
		send_item(OP_ENQ, 25'd16777216, 48'h8000_0000_0000);
		send_item(OP_ACQ, '0, '0);
		send_item(OP_REL, '0, '0);

		// Tiny setting rounds up to one 64-byte unit
		configure(1, 1'b1);
		send_item(OP_ENQ, 25'd64, 48'h0F0F_0F0F_0F0F);
		send_item(OP_ENQ, 25'd65, 48'hF0F0_F0F0_F0F0);

		for (int p = 0; p < PHASES; p++) begin
			configure(PHASE_BYTES[p], PHASE_RUN[p]);
			run_random(PHASE_ITEMS[p]);
		end

		drain_results();
		$display("Covered %0d operations and %0d results over %0d register settings,",
			ledger.items, ledger.results, PHASES + 4);
		$display("  outcomes ok %0d, stopped %0d, too large %0d, empty %0d, ",
			ledger.status_seen[STAT_OK], ledger.status_seen[STAT_STOPPED],
			ledger.status_seen[STAT_TOO_LARGE], ledger.status_seen[STAT_EMPTY],
			"held %0d, none held %0d, drops %0d, releases %0d, mismatches %0d",
			ledger.status_seen[STAT_HELD], ledger.status_seen[STAT_NONE_HELD],
			ledger.drop_count, ledger.release_count, ledger.failures);
		if (ledger.failures == 0 && ledger.awaited.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

### drop_oldest_slot_queue.f
rtl/dosq_pkg.sv
rtl/dosq_scan.sv
rtl/drop_oldest_slot_queue.sv
dv/drop_oldest_slot_queue_test.sv
